### rtl/assert_macros.svh
// Assertion macros shared by the front end, queue and back end modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/u16u8_pkg.sv
// Types, constants and the code point encoder of the UTF-16 to UTF-8 unit.
package u16u8_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam logic [5:0]  HIGH_TAG  = 6'h36;
    localparam logic [5:0]  LOW_TAG   = 6'h37;
    localparam logic [20:0] CP_1B_LIM = 21'h80;
    localparam logic [20:0] CP_2B_LIM = 21'h800;
    localparam logic [20:0] CP_SUPP   = 21'h10000;
    localparam logic [7:0]  LEAD_2B   = 8'hC0;
    localparam logic [7:0]  LEAD_3B   = 8'hE0;
    localparam logic [7:0]  LEAD_4B   = 8'hF0;
    localparam logic [7:0]  CONT_TAG  = 8'h80;
    localparam logic [2:0]  FLUSH_LEN = 3'd3;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      count;
    } t_job;

    function automatic t_enc enc_cp(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < CP_1B_LIM) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp < CP_2B_LIM) begin
            e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_TAG | {2'b00, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp < CP_SUPP) begin
            e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_TAG | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_TAG | {2'b00, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_TAG | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_TAG | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_TAG | {2'b00, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

### rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds byte jobs.
`include "assert_macros.svh"
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [15:0]       i_code_unit,
    input  logic              i_last_unit,
    input  logic              i_q_full,
    output logic              o_push,
    output u16u8_pkg::t_job   o_job
);
    import u16u8_pkg::*;

    logic        r_pend_valid, n_pend_valid;
    logic [9:0]  r_pend_bits, n_pend_bits;
    logic        accept, is_high, is_low, hold;
    logic [20:0] pair_cp, flush_cp, cur_cp;
    t_enc        pair_enc, flush_enc, cur_enc;
    t_job        job;

    assign accept   = i_valid && !i_q_full;
    assign o_stall  = i_q_full;
    assign is_high  = (i_code_unit[15:10] == HIGH_TAG);
    assign is_low   = (i_code_unit[15:10] == LOW_TAG);
    assign hold     = is_high && !i_last_unit;
    assign pair_cp  = {1'b0, r_pend_bits, i_code_unit[9:0]} + CP_SUPP;
    assign flush_cp = {5'b00000, HIGH_TAG, r_pend_bits};
    assign cur_cp   = {5'b00000, i_code_unit};
    assign pair_enc  = enc_cp(pair_cp);
    assign flush_enc = enc_cp(flush_cp);
    assign cur_enc   = enc_cp(cur_cp);

    always_comb begin
        job = '0;
        if (r_pend_valid && is_low) begin
            job.bytes[3:0] = pair_enc.bytes;
            job.count      = pair_enc.len;
        end else if (r_pend_valid) begin
            job.bytes[2:0] = flush_enc.bytes[2:0];
            job.count      = FLUSH_LEN;
            if (!hold) begin
                job.bytes[5:3] = cur_enc.bytes[2:0];
                job.count      = FLUSH_LEN + cur_enc.len;
            end
        end else if (!hold) begin
            job.bytes[2:0] = cur_enc.bytes[2:0];
            job.count      = cur_enc.len;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.count != 3'd0);

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_bits  = r_pend_bits;
        if (accept) begin
            if (hold && !(r_pend_valid && is_low)) begin
                n_pend_valid = 1'b1;
                n_pend_bits  = i_code_unit[9:0];
            end else begin
                n_pend_valid = 1'b0;
                n_pend_bits  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_bits  <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_bits  <= n_pend_bits;
        end
    end

    `ASSERT_NEXT(a_last_clears_pending, i_clk, i_rst_n, accept && i_last_unit, !r_pend_valid)
    `ASSERT_IMPLIES(a_hold_no_push, i_clk, i_rst_n, accept && hold && !r_pend_valid, !o_push)
endmodule

### rtl/u16u8_queue.sv
// Short job queue between the front end and the byte serializer.
`include "assert_macros.svh"
module u16u8_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_head_valid,
    output u16u8_pkg::t_job   o_head
);
    import u16u8_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]  r_count;

    assign o_full       = (r_count == QCW'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, o_head_valid)
endmodule

### rtl/u16u8_back.sv
// Back end: serializes queued jobs into one UTF-8 byte per transaction.
`include "assert_macros.svh"
module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  u16u8_pkg::t_job   i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_run_end
);
    import u16u8_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_ovalid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       out_free, load, last_byte;

    assign out_free  = !r_ovalid || !i_stall;
    assign load      = out_free && i_head_valid;
    assign last_byte = (r_idx == (i_head.count - 3'd1));
    assign o_pop     = load && last_byte;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last_byte ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_end  <= last_byte;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_byte;
    assign o_run_end  = r_end;

    `ASSERT_IMPLIES(a_idx_in_range, i_clk, i_rst_n, i_head_valid, r_idx < i_head.count)
    `ASSERT_NEXT(a_pop_marks_end, i_clk, i_rst_n, o_pop, o_valid && o_run_end)
endmodule

### rtl/utf16_to_utf8_encoder_unit.sv
// Top level of the UTF-16 to UTF-8 encoder unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | i_code_unit[15:0], i_last_unit
//  output  | out       | o_valid / i_stall  | o_out_byte[7:0], o_run_end
//
// One code unit is taken per cycle while the 4-entry job queue has room.
// The serializer sends one byte per cycle while i_stall is low; a unit yields 0 to 6
// bytes, and its job passes through the queue and then the output register.
// Reset clears the pending surrogate, queue pointers and the output valid flag.
// o_stall rises only when the queue is full; i_stall holds the output register.
module utf16_to_utf8_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end
);
    import u16u8_pkg::*;

    logic q_full, q_push, q_pop, q_head_valid;
    t_job push_job, head_job;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    u16u8_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (push_job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (head_job)
    );

    u16u8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (head_job),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end)
    );
endmodule

### tb/utf16_to_utf8_checker.sv
// Transaction checker: predicts UTF-8 bytes from accepted code units and compares outputs.
`timescale 1ns / 100ps

module utf16_to_utf8_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_run_end,
    output int          o_fail_count,
    output int          o_outstanding
);
    import u16u8_pkg::*;

    // {byte, run_end} per expected output transaction
    logic [8:0] utf8_expected[$];
    logic [7:0] staged_bytes[$];
    logic       held_valid;
    logic [9:0] held_bits;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        held_valid    = 1'b0;
        held_bits     = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic stage_byte(input logic [7:0] b);
        staged_bytes.insert(staged_bytes.size(), b);
    endtask

    task automatic stage_code_point(input logic [20:0] cp);
        if (cp < CP_1B_LIM) begin
            stage_byte(cp[7:0]);
        end else if (cp < CP_2B_LIM) begin
            stage_byte(LEAD_2B | {3'b000, cp[10:6]});
            stage_byte(CONT_TAG | {2'b00, cp[5:0]});
        end else if (cp < CP_SUPP) begin
            stage_byte(LEAD_3B | {4'b0000, cp[15:12]});
            stage_byte(CONT_TAG | {2'b00, cp[11:6]});
            stage_byte(CONT_TAG | {2'b00, cp[5:0]});
        end else begin
            stage_byte(LEAD_4B | {5'b00000, cp[20:18]});
            stage_byte(CONT_TAG | {2'b00, cp[17:12]});
            stage_byte(CONT_TAG | {2'b00, cp[11:6]});
            stage_byte(CONT_TAG | {2'b00, cp[5:0]});
        end
    endtask

    task automatic predict_unit(input logic [15:0] cu, input logic last);
        logic is_high;
        logic is_low;
        logic paired;
        logic [8:0] entry;
        is_high = (cu[15:10] == HIGH_TAG);
        is_low  = (cu[15:10] == LOW_TAG);
        paired  = 1'b0;
        staged_bytes.delete();
        if (held_valid) begin
            if (is_low) begin
                stage_code_point({1'b0, held_bits, cu[9:0]} + CP_SUPP);
                paired = 1'b1;
            end else begin
                // flush the held high surrogate on its own
                stage_code_point({5'b00000, HIGH_TAG, held_bits});
            end
            held_valid = 1'b0;
            held_bits  = '0;
        end
        if (!paired) begin
            if (is_high && !last) begin
                held_valid = 1'b1;
                held_bits  = cu[9:0];
            end else begin
                stage_code_point({5'b00000, cu});
            end
        end
        for (int k = 0; k < staged_bytes.size(); k++) begin
            entry = {staged_bytes[k], (k == staged_bytes.size() - 1)};
            utf8_expected.insert(utf8_expected.size(), entry);
        end
    endtask

    always @(posedge i_clk) begin
        logic [8:0] exp_item;
        if (!i_rst_n) begin
            held_valid = 1'b0;
            held_bits  = '0;
            utf8_expected.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_unit(i_code_unit, i_last_unit);
            if (i_out_valid && !i_out_stall) begin
                if (utf8_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h run_end %0b",
                                              i_out_byte, i_run_end));
                end else begin
                    exp_item = utf8_expected.pop_front();
                    if (i_out_byte !== exp_item[8:1])
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  i_out_byte, exp_item[8:1]));
                    if (i_run_end !== exp_item[0])
                        report_mismatch($sformatf("run_end got %0b want %0b (byte %02h)",
                                                  i_run_end, exp_item[0], exp_item[8:1]));
                end
            end
        end
        o_outstanding = utf8_expected.size();
    end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, code unit stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb;
    import u16u8_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [15:0] i_code_unit = '0;
    logic        i_last_unit = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_run_end;

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    t_idle_mode  idle_mode   = IDLE_NONE;
    logic        hold_request = 1'b0;

    always #1 i_clk = ~i_clk;

    utf16_to_utf8_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end)
    );

    utf16_to_utf8_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_code_unit   (i_code_unit),
        .i_last_unit   (i_last_unit),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_run_end     (o_run_end),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf16_to_utf8_encoder_unit regression: fail");
            $finish;
        end
    end

    function automatic logic sender_idles();
        int r;
        r = $urandom_range(99);
        return (idle_mode == IDLE_SEND && r < 52) || (idle_mode == IDLE_BOTH && r < 14);
    endfunction

    function automatic logic receiver_stalls();
        int r;
        r = $urandom_range(99);
        return (idle_mode == IDLE_RECV && r < 52) || (idle_mode == IDLE_BOTH && r < 14);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= receiver_stalls();
            end
        end
    end

    task automatic send_unit(input logic [15:0] cu, input logic last);
        logic taken;
        while (sender_idles()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        i_last_unit <= last;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // random strings: mostly well-formed text, some raw noise units
    task automatic send_random_text(input int unit_target);
        int sent;
        int len;
        int r;
        logic fin;
        sent = 0;
        while (sent < unit_target) begin
            len = $urandom_range(1, 8);
            for (int c = 0; c < len; c++) begin
                fin = (c == len - 1);
                r = $urandom_range(99);
                if (r < 30) begin
                    send_unit(16'($urandom_range(16'h007F)), fin);
                    sent++;
                end else if (r < 45) begin
                    send_unit(16'($urandom_range(16'h07FF, 16'h0080)), fin);
                    sent++;
                end else if (r < 60) begin
                    if ($urandom_range(1))
                        send_unit(16'($urandom_range(16'hD7FF, 16'h0800)), fin);
                    else
                        send_unit(16'($urandom_range(16'hFFFF, 16'hE000)), fin);
                    sent++;
                end else if (r < 85) begin
                    send_unit({HIGH_TAG, 10'($urandom())}, 1'b0);
                    send_unit({LOW_TAG, 10'($urandom())}, fin);
                    sent += 2;
                end else begin
                    send_unit(16'($urandom()), fin);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: length boundaries, surrogate handling
        idle_mode = IDLE_NONE;
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        send_unit(16'hDC00, 1'b0);   // lone low
        send_unit(16'hD800, 1'b0);   // held high, then ascii
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD9AB, 1'b0);   // held high, then 3-byte unit
        send_unit(16'hE000, 1'b0);
        send_unit(16'hDBFF, 1'b1);   // high as last, nothing held
        send_unit(16'hD800, 1'b0);   // held high, then high as last
        send_unit(16'hDB00, 1'b1);
        send_unit(16'hD801, 1'b0);   // held high replaced by high
        send_unit(16'hD802, 1'b0);
        send_unit(16'hDC01, 1'b1);
        send_unit(16'hFFFF, 1'b0);

        idle_mode = IDLE_NONE;
        send_random_text(32);
        idle_mode = IDLE_SEND;
        send_random_text(32);
        idle_mode = IDLE_RECV;
        send_random_text(32);
        idle_mode = IDLE_BOTH;
        send_random_text(32);

        // long receiver hold-off while the sender keeps pushing
        idle_mode = IDLE_NONE;
        hold_request = 1'b1;
        send_random_text(16);
        i_valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("utf16_to_utf8_encoder_unit regression: pass");
        else
            $display("utf16_to_utf8_encoder_unit regression: fail");
        $finish;
    end

endmodule
